// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property checked on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/core/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants for the stream duplicate filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdf_pkg;

  localparam int SDF_MAX_DISTINCT = 32;
  localparam int SDF_VALUE_W      = 32;
  localparam int SDF_SLOT_W       = 5;
  localparam int SDF_COUNT_W      = 6;

  typedef struct packed {
    logic signed [SDF_VALUE_W-1:0] value;
    logic                          last;
  } in_beat_t;

  typedef struct packed {
    logic signed [SDF_VALUE_W-1:0] echo_value;
    logic                          is_new;
    logic [SDF_SLOT_W-1:0]         slot;
    logic [SDF_COUNT_W-1:0]        distinct_count;
    logic                          dropped;
    logic                          end_of_sequence;
  } out_beat_t;

  // Token handed from cell to cell along the chain.
  typedef struct packed {
    logic                          vld;
    logic                          last;
    logic                          matched;
    logic                          inserted;
    logic signed [SDF_VALUE_W-1:0] value;
  } sdf_tok_t;

endpackage

// ===== rtl/core/sdf_cell.sv =====
// ----------------------------------------------------------------------------
// sdf_cell
// One store entry of the chain: compares the passing beat, appends it if the
// entry is free, and forwards the token one stage on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdf_cell
  import sdf_pkg::*;
#(
  parameter int SLOT_W = SDF_SLOT_W,
  parameter int CNT_W  = SDF_COUNT_W,
  parameter int IDX    = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  sdf_tok_t          tok_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [CNT_W-1:0]  cnt_i,
  output sdf_tok_t          tok_o,
  output logic [SLOT_W-1:0] slot_o,
  output logic [CNT_W-1:0]  cnt_o
);

  logic signed [SDF_VALUE_W-1:0] entry_r;
  logic                          occ_r, occ_nxt;
  sdf_tok_t                      tok_r, tok_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          open_tok, hit, take;

  assign open_tok = tok_i.vld && !tok_i.matched && !tok_i.inserted;
  assign hit      = open_tok && occ_r && (entry_r == tok_i.value);
  assign take     = open_tok && !occ_r;

  always_comb begin
    tok_nxt          = tok_i;
    tok_nxt.matched  = tok_i.matched | hit;
    tok_nxt.inserted = tok_i.inserted | take;
    slot_nxt         = (hit || take) ? SLOT_W'(IDX) : slot_i;
    cnt_nxt          = cnt_i + CNT_W'(occ_r || take);
    // the last beat of a sequence empties each entry as it passes
    if (tok_i.vld && tok_i.last) begin
      occ_nxt = 1'b0;
    end else begin
      occ_nxt = occ_r | take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      tok_r  <= '0;
      slot_r <= '0;
      cnt_r  <= '0;
    end else if (en) begin
      occ_r  <= occ_nxt;
      tok_r  <= tok_nxt;
      slot_r <= slot_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && take) begin
      entry_r <= tok_i.value;
    end
  end

  assign tok_o  = tok_r;
  assign slot_o = slot_r;
  assign cnt_o  = cnt_r;

endmodule

// ===== rtl/core/stream_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// stream_duplicate_filter
// First-occurrence dedup of a signed 32-bit stream over a chain of cells.
// ----------------------------------------------------------------------------
//  channel | ports                          | role
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data    | value plus end-of-sequence flag
//  output  | out_valid, out_ready, out_data | one result beat per input beat
//
//  One beat enters per cycle; each beat crosses the cell chain one cell per
//  cycle, and the last cell's registers drive the output. Reset empties
//  every cell and the chain. A stalled output freezes the whole chain, and
//  in_ready drops with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stream_duplicate_filter
  import sdf_pkg::*;
#(
  parameter int MAX_DISTINCT = SDF_MAX_DISTINCT
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  localparam int SLOT_W = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
  localparam int CNT_W  = $clog2(MAX_DISTINCT + 1);

  sdf_tok_t          tok  [0:MAX_DISTINCT];
  logic [SLOT_W-1:0] slot [0:MAX_DISTINCT];
  logic [CNT_W-1:0]  cnt  [0:MAX_DISTINCT];
  logic              en;
  sdf_tok_t          tok_end;
  logic              end_both, end_drop, end_claim, end_full, end_slot_ok;

  assign tok_end = tok[MAX_DISTINCT];
  assign en      = !tok_end.vld || out_ready;
  assign in_ready = en;

  assign tok[0] = '{vld: in_valid, last: in_data.last, matched: 1'b0,
                    inserted: 1'b0, value: in_data.value};
  assign slot[0] = '0;
  assign cnt[0]  = '0;

  for (genvar k = 0; k < MAX_DISTINCT; k++) begin : g_cell
    sdf_cell #(
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .IDX    (k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .tok_i  (tok[k]),
      .slot_i (slot[k]),
      .cnt_i  (cnt[k]),
      .tok_o  (tok[k+1]),
      .slot_o (slot[k+1]),
      .cnt_o  (cnt[k+1])
    );
  end

  // slot stays zero on a drop: no cell claimed the beat
  always_comb begin
    out_data.echo_value      = tok_end.value;
    out_data.is_new          = !tok_end.matched;
    out_data.slot            = SDF_SLOT_W'(slot[MAX_DISTINCT]);
    out_data.distinct_count  = SDF_COUNT_W'(cnt[MAX_DISTINCT]);
    out_data.dropped         = !tok_end.matched && !tok_end.inserted;
    out_data.end_of_sequence = tok_end.last;
  end

  assign out_valid = tok_end.vld;

  assign end_both    = tok_end.vld && tok_end.matched && tok_end.inserted;
  assign end_drop    = tok_end.vld && !tok_end.matched && !tok_end.inserted;
  assign end_claim   = tok_end.vld && (tok_end.matched || tok_end.inserted);
  assign end_full    = (cnt[MAX_DISTINCT] == CNT_W'(MAX_DISTINCT));
  assign end_slot_ok = (CNT_W'(slot[MAX_DISTINCT]) < cnt[MAX_DISTINCT]);

  `ASSERT_NEVER(a_hit_and_append, clk, rst_n, end_both, "beat both matched and appended")
  `ASSERT_PROP(a_drop_when_full, clk, rst_n, end_drop |-> end_full, "drop with store not full")
  `ASSERT_PROP(a_slot_below_count, clk, rst_n, end_claim |-> end_slot_ok, "slot not below count")

endmodule

// ===== tb/stream_duplicate_filter_tb.sv =====
// ----------------------------------------------------------------------------
// stream_duplicate_filter_tb
// Drives value sequences into the duplicate filter and checks every result
// beat against an in-bench dedup predictor: extremes, a full store with
// dropped values, random sequences with stray ends, and a full-rate burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stream_duplicate_filter_tb;
  import sdf_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  stream_duplicate_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  localparam logic signed [SDF_VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [SDF_VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // predictor state: distinct values of the open sequence
  logic signed [SDF_VALUE_W-1:0] seen_values [SDF_MAX_DISTINCT];
  int unsigned                   seen_count;
  out_beat_t                     expected_results [$];
  int unsigned                   mismatch_count;
  bit                            gaps_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= !gaps_on || ($urandom_range(99) >= 13);
  end

  task automatic check_field(input string field, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch on %s: expected %h, got %h", field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: %h", out_data);
      end else begin
        want = expected_results.pop_front();
        check_field("echo_value", want.echo_value, out_data.echo_value);
        check_field("is_new", want.is_new, out_data.is_new);
        check_field("slot", want.slot, out_data.slot);
        check_field("distinct_count", want.distinct_count, out_data.distinct_count);
        check_field("dropped", want.dropped, out_data.dropped);
        check_field("end_of_sequence", want.end_of_sequence, out_data.end_of_sequence);
      end
    end
  end

  task automatic dedup_predict(input in_beat_t beat);
    out_beat_t r;
    int        hit;
    hit = -1;
    for (int k = 0; k < seen_count; k++)
      if (hit < 0 && seen_values[k] == beat.value) hit = k;
    r.echo_value      = beat.value;
    r.end_of_sequence = beat.last;
    r.dropped         = 1'b0;
    r.slot            = '0;
    if (hit >= 0) begin
      r.is_new = 1'b0;
      r.slot   = SDF_SLOT_W'(hit);
    end else begin
      r.is_new = 1'b1;
      if (seen_count < SDF_MAX_DISTINCT) begin
        seen_values[seen_count] = beat.value;
        r.slot = SDF_SLOT_W'(seen_count);
        seen_count++;
      end else begin
        r.dropped = 1'b1;
      end
    end
    r.distinct_count = SDF_COUNT_W'(seen_count);
    if (beat.last) seen_count = 0;
    expected_results.push_back(r);
  endtask

  // valid is only lowered when a gap is taken, so back-to-back beats keep it high
  task automatic send_beat(input logic signed [SDF_VALUE_W-1:0] v, input logic lst);
    in_beat_t beat;
    beat.value = v;
    beat.last  = lst;
    while (gaps_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    dedup_predict(beat);
  endtask

  function automatic logic signed [SDF_VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_extremes();
    send_beat(VAL_MIN, 1'b0);
    send_beat(VAL_MAX, 1'b0);
    send_beat(0, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(VAL_MIN, 1'b0);
    send_beat(-1, 1'b0);
    send_beat(32'sh5555_5555, 1'b0);
    send_beat(32'shaaaa_aaaa, 1'b0);
    send_beat(VAL_MAX, 1'b1);        // repeat closes the sequence
    send_beat(0, 1'b1);              // one-beat sequence
    send_beat(0, 1'b0);              // new again after the clear
    send_beat(1, 1'b1);
  endtask

  task automatic test_store_full();
    logic signed [SDF_VALUE_W-1:0] fill [SDF_MAX_DISTINCT];
    logic signed [SDF_VALUE_W-1:0] v;
    bool_loop: for (int i = 0; i < SDF_MAX_DISTINCT; i++) begin
      v = $urandom;
      fill[i] = {5'(i), v[26:0]};
      send_beat(fill[i], 1'b0);
    end
    repeat (2) begin
      v = $urandom;
      v[31:27] = v[31:27] ^ 5'h1f;
      // top bits alone cannot make it fresh; compare against the whole fill
      for (int i = 0; i < SDF_MAX_DISTINCT; i++)
        if (fill[i] == v) v = v + 1;
      send_beat(v, 1'b0);            // store full: dropped
    end
    send_beat(fill[SDF_MAX_DISTINCT-1], 1'b0);
    send_beat(fill[0], 1'b0);
    send_beat(v, 1'b1);
    send_beat(fill[5], 1'b1);        // fresh sequence after a full one
  endtask

  task automatic test_random_sequences(input int unsigned n_items);
    logic signed [SDF_VALUE_W-1:0] pool [$];
    int unsigned sent;
    int unsigned seq_len;
    int unsigned pool_size;
    logic        lst;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        seq_len   = $urandom_range(33, 60);
        pool_size = $urandom_range(28, 48);
      end else begin
        seq_len   = $urandom_range(1, 30);
        pool_size = $urandom_range(1, 24);
      end
      pool.delete();
      repeat (pool_size) pool.push_back(pick_value());
      for (int i = 0; i < seq_len; i++) begin
        // a stray last now and then breaks a sequence early
        lst = (i == seq_len - 1) || ($urandom_range(99) < 3);
        send_beat(pool[$urandom_range(pool_size - 1)], lst);
        sent++;
      end
    end
  endtask

  task automatic test_full_rate();
    gaps_on = 1'b0;
    test_random_sequences(150);
    gaps_on = 1'b1;
  endtask

  initial begin
    int unsigned drain_cycles;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    seen_count     = 0;
    mismatch_count = 0;
    gaps_on        = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_store_full();
    test_random_sequences(600);
    test_full_rate();

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (2 * SDF_MAX_DISTINCT) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
